[rtl/core/ppx_pkg.sv]
`default_nettype none

package ppx_pkg;

  // configuration register indexes
  localparam logic CFG_BPP_CODE     = 1'b0;
  localparam logic CFG_PALETTE_SIZE = 1'b1;

  localparam logic [1:0] BPP_CODE_RST     = 2'd3;
  localparam logic [8:0] PALETTE_SIZE_RST = 9'd256;

  // input func codes
  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_EXPAND    = 1'b1;

  // one operation travelling down the pixel pipe
  typedef struct packed {
    logic        pix;     // pixel lookup, else palette write
    logic [7:0]  slot;
    logic [14:0] color;
    logic [7:0]  raw;     // unreduced index
    logic [7:0]  rem;     // partial remainder
    logic        last;
  } ppx_op_t;

  typedef logic [31:0][7:0] widen_tab_t;

  // 5-bit channel to 8 bits, (c*255+15)/31, built at elaboration
  function automatic widen_tab_t build_widen_tab();
    widen_tab_t tab;
    for (int i = 0; i < 32; i++) begin
      tab[i] = 8'((i * 255 + 15) / 31);
    end
    return tab;
  endfunction

  localparam widen_tab_t WIDEN_TAB = build_widen_tab();

  // one restoring remainder step: shift in one index bit, subtract if it fits
  function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic b,
                                          input logic [8:0] modulus);
    logic [9:0] t;
    t = {1'b0, rem, b};
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/packed_palette_pixel_expander.sv]
`default_nettype none

// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata: slot, color, packed byte; tuser: func;
//         |     |                      | tlast: last byte of a tile
// out_    | out | out_tvalid/out_tready| tdata: index, red, green, blue, alpha;
//         |     |                      | tlast: last pixel
// cfg_    | in  | cfg_wr_en            | cfg_index, cfg_wdata
//
// one pixel leaves per cycle while the output is not stalled: an expand request issues 8/bpp
// ops (8, 4, 2 or 1), a palette write one op; the splitter register at the front sets this rate
// path from request to first pixel: splitter, 5 remainder stages, ram, output
// rst_n is synchronous active low; it clears valid bits and configuration, not the palette
// a stalled output freezes the whole pipe, nothing is dropped or repeated

module packed_palette_pixel_expander #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  // requests in
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // palette_slot[7:0], palette_color[23:8], packed_byte[31:24]
  input  wire logic        in_tuser,   // func
  input  wire logic        in_tlast,   // last_byte
  // pixels out
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // pixel_index, red, green, blue, alpha from bit 0 up
  output      logic        out_tlast   // last_pixel
);

  import ppx_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int NDIV = 4;  // remainder stages, two index bits each

  // configuration registers; modulus already has zero mapped to one
  logic [1:0] bpp_code_r;
  logic [8:0] modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_code_r <= BPP_CODE_RST;
      modulus_r  <= PALETTE_SIZE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BPP_CODE:     bpp_code_r <= cfg_wdata[1:0];
        CFG_PALETTE_SIZE: modulus_r  <= (cfg_wdata == 9'd0) ? 9'd1 : cfg_wdata;
      endcase
    end
  end

  // whole pipe moves when the output register is free or being drained
  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_tready;

  // splitter: holds the current request and issues one op per cycle while the pipe advances
  logic        sp_busy_r, sp_busy_nxt;
  logic [2:0]  sp_cnt_r, sp_cnt_nxt;      // ops still to issue after this one
  logic [7:0]  sp_byte_r, sp_byte_nxt;
  logic [1:0]  sp_code_r, sp_code_nxt;
  logic        sp_pix_r, sp_pix_nxt;
  logic [7:0]  sp_slot_r, sp_slot_nxt;
  logic [14:0] sp_color_r, sp_color_nxt;
  logic        sp_last_r, sp_last_nxt;
  logic        in_acc;
  logic [7:0]  sp_mask;

  // a new request is taken on the cycle the last op of the old one issues
  assign in_tready = adv && (!sp_busy_r || sp_cnt_r == 3'd0);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    case (sp_code_r)
      2'd0:    sp_mask = 8'h01;
      2'd1:    sp_mask = 8'h03;
      2'd2:    sp_mask = 8'h0F;
      default: sp_mask = 8'hFF;
    endcase
  end

  always_comb begin
    sp_busy_nxt  = sp_busy_r;
    sp_cnt_nxt   = sp_cnt_r;
    sp_byte_nxt  = sp_byte_r;
    sp_code_nxt  = sp_code_r;
    sp_pix_nxt   = sp_pix_r;
    sp_slot_nxt  = sp_slot_r;
    sp_color_nxt = sp_color_r;
    sp_last_nxt  = sp_last_r;
    if (adv) begin
      if (sp_busy_r && sp_cnt_r != 3'd0) begin
        // next pixel of the same byte
        sp_cnt_nxt  = sp_cnt_r - 3'd1;
        sp_byte_nxt = sp_byte_r >> (4'd1 << sp_code_r);
      end else if (in_acc) begin
        sp_busy_nxt  = 1'b1;
        sp_pix_nxt   = (in_tuser == FUNC_EXPAND);
        sp_cnt_nxt   = (in_tuser == FUNC_EXPAND) ? 3'((4'd8 >> bpp_code_r) - 4'd1) : 3'd0;
        sp_code_nxt  = bpp_code_r;
        sp_slot_nxt  = in_tdata[7:0];
        sp_color_nxt = in_tdata[22:8];  // bit 15 of the color is dropped
        sp_byte_nxt  = in_tdata[31:24];
        sp_last_nxt  = in_tlast;
      end else begin
        sp_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_busy_r <= 1'b0;
    end else begin
      sp_busy_r <= sp_busy_nxt;
    end
    sp_cnt_r   <= sp_cnt_nxt;
    sp_byte_r  <= sp_byte_nxt;
    sp_code_r  <= sp_code_nxt;
    sp_pix_r   <= sp_pix_nxt;
    sp_slot_r  <= sp_slot_nxt;
    sp_color_r <= sp_color_nxt;
    sp_last_r  <= sp_last_nxt;
  end

  // remainder pipe: stage 0 takes the issued op, each later stage
  // folds two more index bits into the remainder, msb first
  ppx_op_t        d_r   [NDIV+1];
  ppx_op_t        d_nxt [NDIV+1];
  logic [NDIV:0]  dv_r;

  always_comb begin
    d_nxt[0].pix   = sp_pix_r;
    d_nxt[0].slot  = sp_slot_r;
    d_nxt[0].color = sp_color_r;
    d_nxt[0].raw   = sp_byte_r & sp_mask;
    d_nxt[0].rem   = 8'd0;
    d_nxt[0].last  = sp_pix_r && sp_last_r && sp_cnt_r == 3'd0;
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    always_comb begin
      d_nxt[k+1]     = d_r[k];
      d_nxt[k+1].rem = mod_step(mod_step(d_r[k].rem, d_r[k].raw[7-2*k], modulus_r),
                                d_r[k].raw[6-2*k], modulus_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[NDIV-1:0], sp_busy_r};
    end
  end

  for (genvar k = 0; k <= NDIV; k++) begin : g_dreg
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  // palette access; reduced index wraps onto the store depth by a constant table
  logic [AW-1:0] wrap_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tab[g] = AW'(g % PALETTE_DEPTH);
  end

  ppx_op_t       tail;
  logic          pal_we;
  logic [14:0]   pal_q;

  assign tail   = d_r[NDIV];
  // writes to slots beyond the store are dropped
  assign pal_we = adv && dv_r[NDIV] && !tail.pix && ({1'b0, tail.slot} < 9'(PALETTE_DEPTH));

  ppx_ram #(
    .WIDTH(15),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(tail.slot[AW-1:0]),
    .wdata(tail.color),
    .re   (adv),
    .raddr(wrap_tab[tail.rem]),
    .rdata(pal_q)
  );

  // lookup stage, lines up with the registered ram data
  logic       lk_valid_r;
  logic [7:0] lk_idx_r;
  logic       lk_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r <= 1'b0;
    end else if (adv) begin
      lk_valid_r <= dv_r[NDIV] && tail.pix;
    end
    if (adv) begin
      lk_idx_r  <= tail.rem;
      lk_last_r <= tail.last;
    end
  end

  // output register: channel widening and alpha
  logic [7:0] out_idx_r, out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= lk_valid_r;
    end
    if (adv) begin
      out_idx_r   <= lk_idx_r;
      out_red_r   <= WIDEN_TAB[pal_q[4:0]];
      out_green_r <= WIDEN_TAB[pal_q[9:5]];
      out_blue_r  <= WIDEN_TAB[pal_q[14:10]];
      out_alpha_r <= (lk_idx_r == 8'd0) ? 8'd0 : 8'd255;
      out_last_r  <= lk_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_alpha_r, out_blue_r, out_green_r, out_red_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/ppx_ram.sv]
`default_nettype none

module ppx_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
  import ppx_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;   // pipe depth is 8, palette writes give no pixel

  // one request as the sender sees it
  typedef struct {
    logic        func;
    logic [7:0]  slot;
    logic [15:0] color;
    logic [7:0]  pixels;
    logic        last;
  } request_t;

  // one expected output pixel
  typedef struct {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_BPP_CODE;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // palette_slot[7:0], palette_color[23:8], packed_byte[31:24]
  logic        in_tuser = 1'b0; // func
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // pixel_index, red, green, blue, alpha from bit 0 up
  logic        out_tlast;       // last_pixel

  packed_palette_pixel_expander DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // requests waiting for the driver, pixels waiting for the monitor
  request_t request_q[$];
  pixel_t   pixel_q[$];

  // predictor copy of configuration and palette
  logic [1:0]  bpp_code_shadow = BPP_CODE_RST;
  logic [8:0]  palette_size_shadow = PALETTE_SIZE_RST;
  logic [14:0] palette_shadow [256];

  // which palette slots the stimulus has already written, so no unwritten entry is read
  bit          slot_loaded [256];

  int          error_count = 0;
  int          cycle_count = 0;

  // sender and receiver idling
  request_t    held_req;
  int          tx_gap = 0;
  int          rx_wait = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  // 5-bit channel widened to 8 bits with rounding
  function automatic logic [7:0] widen5to8(input logic [4:0] c);
    int unsigned v;
    v = (int'(c) * 255 + 15) / 31;
    return v[7:0];
  endfunction

  // number of indices per byte and the reduced index of pixel k, under the current setting
  function automatic int pixels_per_byte();
    return 8 >> bpp_code_shadow;
  endfunction

  function automatic logic [7:0] reduced_index(input logic [7:0] pixels, input int k);
    int unsigned bpp, raw, modulus;
    bpp = 1 << bpp_code_shadow;
    raw = (pixels >> (k * bpp)) & ((1 << bpp) - 1);
    modulus = (palette_size_shadow == 0) ? 1 : palette_size_shadow; // zero size acts as one
    return 8'((raw % modulus) & 8'hFF);
  endfunction

  // expected pixels of one accepted expand request
  task automatic predict_pixels(input logic [7:0] pixels, input logic last);
    int     count;
    pixel_t p;
    logic [14:0] entry;
    count = pixels_per_byte();
    for (int k = 0; k < count; k++) begin
      p.index = reduced_index(pixels, k);
      entry   = palette_shadow[p.index];
      p.red   = widen5to8(entry[4:0]);
      p.green = widen5to8(entry[9:5]);
      p.blue  = widen5to8(entry[14:10]);
      p.alpha = (p.index == 0) ? 8'd0 : 8'd255;
      p.last  = last && (k == count - 1);
      pixel_q.push_back(p);
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  task automatic check_pixel(input logic [39:0] data, input logic last);
    pixel_t want;
    if (pixel_q.size() == 0) begin
      flag_mismatch("unexpected pixel, index", data[7:0], -1);
    end else begin
      want = pixel_q.pop_front();
      if (data[7:0] !== want.index) flag_mismatch("pixel_index", data[7:0], want.index);
      if (data[15:8] !== want.red) flag_mismatch("red", data[15:8], want.red);
      if (data[23:16] !== want.green) flag_mismatch("green", data[23:16], want.green);
      if (data[31:24] !== want.blue) flag_mismatch("blue", data[31:24], want.blue);
      if (data[39:32] !== want.alpha) flag_mismatch("alpha", data[39:32], want.alpha);
      if (last !== want.last) flag_mismatch("last_pixel", last, want.last);
    end
  endtask

  // stimulus helpers
  task automatic add_write(input logic [7:0] slot, input logic [15:0] color, input logic last);
    request_t r;
    r.func = FUNC_PAL_WRITE;
    r.slot = slot;
    r.color = color;
    r.pixels = 8'($urandom_range(0, 255));  // don't care on a palette write
    r.last = last;
    slot_loaded[slot] = 1'b1;
    request_q.push_back(r);
  endtask

  // loads any slot the byte would read that has no color yet, then queues the expand
  task automatic add_expand(input logic [7:0] pixels, input logic last);
    request_t r;
    logic [7:0] idx;
    for (int k = 0; k < pixels_per_byte(); k++) begin
      idx = reduced_index(pixels, k);
      if (!slot_loaded[idx]) add_write(idx, 16'($urandom_range(0, 65535)), 1'($urandom));
    end
    r.func = FUNC_EXPAND;
    r.slot = 8'($urandom_range(0, 255));
    r.color = 16'($urandom_range(0, 65535));
    r.pixels = pixels;
    r.last = last;
    request_q.push_back(r);
  endtask

  task automatic random_requests(input int n);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        add_write(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'($urandom));
      end else if (pick < 28) begin
        // all-zero and all-one bytes
        add_expand(pick[0] ? 8'hFF : 8'h00, 1'($urandom));
      end else begin
        add_expand(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // wait until the block is empty: no request pending or held, no pixel outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic apply_config(input logic [1:0] bpp_code, input logic [8:0] palette_size);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BPP_CODE;
    cfg_wdata <= {7'd0, bpp_code};
    @(posedge clk);
    cfg_index <= CFG_PALETTE_SIZE;
    cfg_wdata <= palette_size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bpp_code_shadow = bpp_code;
    palette_size_shadow = palette_size;
  endtask

  // driver: presents the held request until accepted, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (held_req.func == FUNC_EXPAND) begin
          predict_pixels(held_req.pixels, held_req.last);
        end else begin
          palette_shadow[held_req.slot] = held_req.color[14:0];  // bit 15 dropped
        end
        if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 4);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          held_req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {held_req.pixels, held_req.color, held_req.slot};
          in_tuser <= held_req.func;
          in_tlast <= held_req.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted pixel and stalls at random between pixels
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_pixel(out_tdata, out_tlast);
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // hard stop for a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset setting: 8 bits per pixel, full palette
    add_write(8'd0, 16'h0000, 1'b0);
    add_write(8'd255, 16'hFFFF, 1'b1);   // top bit must be dropped
    add_write(8'd1, 16'h001F, 1'b0);     // red only
    add_write(8'd2, 16'h03E0, 1'b0);     // green only
    add_write(8'd3, 16'h7C00, 1'b0);     // blue only
    add_write(8'd128, 16'h7FFF, 1'b0);
    add_write(8'd85, 16'h8000, 1'b1);    // only the ignored bit set
    add_expand(8'h00, 1'b0);             // index zero, alpha zero
    add_expand(8'hFF, 1'b1);
    add_expand(8'h01, 1'b0);
    add_expand(8'h02, 1'b0);
    add_expand(8'h03, 1'b1);
    add_expand(8'h80, 1'b0);
    add_expand(8'h55, 1'b1);

    // 1 bit per pixel, first pixel from bit 0
    apply_config(2'd0, 9'd256);
    add_expand(8'hFF, 1'b1);
    add_expand(8'h00, 1'b0);
    add_expand(8'h5A, 1'b1);

    // zero palette size folds every index to zero
    apply_config(2'd1, 9'd0);
    add_expand(8'hE4, 1'b1);

    // palette size above 256, no reduction
    apply_config(2'd2, 9'd511);
    add_expand(8'hF0, 1'b1);
    add_expand(8'h3C, 1'b0);

    // random phases over a spread of settings, extremes included
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: apply_config(2'd3, 9'd256);
        1: apply_config(2'd0, 9'd1);
        2: apply_config(2'd1, 9'd4);
        3: apply_config(2'd2, 9'd16);
        4: apply_config(2'd3, 9'd0);
        5: apply_config(2'd2, 9'd300);
        6: apply_config(2'd1, 9'd3);
        7: apply_config(2'd3, 9'($urandom_range(1, 256)));
        default: apply_config(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)));
      endcase
      random_requests(40);
    end

    // drain, then let the pipe settle before the verdict
    wait_idle();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
